[rtl/npcr_pkg.sv]
// Shared types and constants for the MIPS next-pc resolver.
// Used by every module under rtl/; depends on nothing else.
package npcr_pkg;

  localparam int NPCR_ADDR_WIDTH = 64;

  // Which candidate address the final stage picks.
  typedef enum logic [2:0] {
    SEL_PLUS4  = 3'd0,
    SEL_PLUS8  = 3'd1,
    SEL_BRANCH = 3'd2,
    SEL_JUMP   = 3'd3,
    SEL_JREG   = 3'd4
  } npcr_sel_t;

  typedef struct packed {
    npcr_sel_t sel;
    logic      taken;
  } npcr_ctl_t;

endpackage

[rtl/mips_next_pc_resolver_unit.sv]
// Next-pc resolver for single-stepping MIPS code: for each instruction it gives the
// address of the step breakpoint. Three register stages (decode and branch condition,
// candidate address adds, final select into the output register) take one transfer
// per cycle while item_stall is low; each result passes through the decode, target
// and select registers to the output. A stall holds only the stages that are full,
// so bubbles close up. Addresses wrap modulo 2^ADDR_WIDTH and bits above it read as
// zero.
module mips_next_pc_resolver_unit import npcr_pkg::*; #(
  parameter int ADDR_WIDTH = NPCR_ADDR_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [63:0]        pc,
  input  logic [31:0]        instruction,
  input  logic signed [63:0] rs_value,
  input  logic signed [63:0] rt_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [63:0]        next_pc
);

  logic                  v1;
  logic                  v2;
  npcr_ctl_t             ctl1;
  npcr_ctl_t             ctl2;
  logic [ADDR_WIDTH-1:0] pc1;
  logic [15:0]           offset1;
  logic [25:0]           index1;
  logic [ADDR_WIDTH-1:0] rs1;
  logic [ADDR_WIDTH-1:0] seq4;
  logic [ADDR_WIDTH-1:0] seq8;
  logic [ADDR_WIDTH-1:0] branch;
  logic [ADDR_WIDTH-1:0] jump;
  logic [ADDR_WIDTH-1:0] jreg;
  logic                  adv1;
  logic                  adv2;
  logic                  adv3;

  assign adv3       = !result_valid || !result_stall;
  assign adv2       = !v2 || adv3;
  assign adv1       = !v1 || adv2;
  assign item_stall = !adv1;

  npcr_decode #(.ADDR_WIDTH(ADDR_WIDTH)) u_decode (
    .clk         (clk),
    .rst         (rst),
    .en          (adv1),
    .item_valid  (item_valid),
    .pc          (pc),
    .instruction (instruction),
    .rs_value    (rs_value),
    .rt_value    (rt_value),
    .v           (v1),
    .ctl         (ctl1),
    .pc_q        (pc1),
    .offset      (offset1),
    .index       (index1),
    .rs_q        (rs1)
  );

  npcr_target #(.ADDR_WIDTH(ADDR_WIDTH)) u_target (
    .clk    (clk),
    .rst    (rst),
    .en     (adv2),
    .v_in   (v1),
    .ctl_in (ctl1),
    .pc_in  (pc1),
    .offset (offset1),
    .index  (index1),
    .rs_in  (rs1),
    .v      (v2),
    .ctl    (ctl2),
    .seq4   (seq4),
    .seq8   (seq8),
    .branch (branch),
    .jump   (jump),
    .jreg   (jreg)
  );

  npcr_select #(.ADDR_WIDTH(ADDR_WIDTH)) u_select (
    .clk     (clk),
    .rst     (rst),
    .en      (adv3),
    .v_in    (v2),
    .ctl     (ctl2),
    .seq4    (seq4),
    .seq8    (seq8),
    .branch  (branch),
    .jump    (jump),
    .jreg    (jreg),
    .v       (result_valid),
    .next_pc (next_pc)
  );

  // Pipeline empties on reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !v1 && !v2 && !result_valid)
    else $error("pipeline not empty after reset");

  // An input transfer always lands in stage 1.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> v1)
    else $error("accepted item lost at stage 1");

  // A full stage 2 behind a stalled output must hold its item.
  a_stage2_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall && v2) |=> v2 && $stable(seq4))
    else $error("stage 2 item dropped under stall");

  // Stall to the input only when every stage is full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> v1 && v2 && result_valid && result_stall)
    else $error("input stalled with room in the pipeline");

  // Result never carries bits above the address width.
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (next_pc >> ADDR_WIDTH) == 64'd0)
    else $error("next_pc exceeds address width");

endmodule

[rtl/npcr_decode.sv]
// Stage 1: instruction decode and branch condition evaluation.
// Depends on npcr_pkg.
module npcr_decode import npcr_pkg::*; #(
  parameter int ADDR_WIDTH = NPCR_ADDR_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   item_valid,
  input  logic [63:0]            pc,
  input  logic [31:0]            instruction,
  input  logic signed [63:0]     rs_value,
  input  logic signed [63:0]     rt_value,
  output logic                   v,
  output npcr_ctl_t              ctl,
  output logic [ADDR_WIDTH-1:0]  pc_q,
  output logic [15:0]            offset,
  output logic [25:0]            index,
  output logic [ADDR_WIDTH-1:0]  rs_q
);

  localparam logic [31:0] MASK_OP  = 32'hfc000000;
  localparam logic [31:0] MASK_RI  = 32'hfc1f0000;
  localparam logic [31:0] MASK_COP = 32'hf3fc0000;
  localparam logic [31:0] MASK_JR  = 32'hfc1fffff;
  localparam logic [31:0] MASK_JAL = 32'hfc1f07ff;

  localparam logic [31:0] PAT_BCZ     = 32'h41000000;
  localparam logic [31:0] PAT_BGEZALL = 32'h04130000;
  localparam logic [31:0] PAT_BGEZL   = 32'h04030000;
  localparam logic [31:0] PAT_BGTZL   = 32'h5c000000;
  localparam logic [31:0] PAT_BLEZL   = 32'h58000000;
  localparam logic [31:0] PAT_BLTZALL = 32'h04120000;
  localparam logic [31:0] PAT_BLTZL   = 32'h04020000;
  localparam logic [31:0] PAT_BEQL    = 32'h50000000;
  localparam logic [31:0] PAT_BNEL    = 32'h54000000;
  localparam logic [31:0] PAT_J       = 32'h08000000;
  localparam logic [31:0] PAT_JAL     = 32'h0c000000;
  localparam logic [31:0] PAT_JALR    = 32'h00000009;
  localparam logic [31:0] PAT_JR      = 32'h00000008;
  localparam logic [31:0] PAT_BEQ     = 32'h10000000;
  localparam logic [31:0] PAT_BGEZ    = 32'h04010000;
  localparam logic [31:0] PAT_BGEZAL  = 32'h04110000;
  localparam logic [31:0] PAT_BGTZ    = 32'h1c000000;
  localparam logic [31:0] PAT_BLEZ    = 32'h18000000;
  localparam logic [31:0] PAT_BLTZ    = 32'h04000000;
  localparam logic [31:0] PAT_BLTZAL  = 32'h04100000;
  localparam logic [31:0] PAT_BNE     = 32'h14000000;
  localparam logic [31:0] PAT_BBIT0   = 32'hc8000000;
  localparam logic [31:0] PAT_BBIT032 = 32'hd8000000;
  localparam logic [31:0] PAT_BBIT1   = 32'he8000000;
  localparam logic [31:0] PAT_BBIT132 = 32'hf8000000;

  logic [31:0] op;
  logic [31:0] ri;
  logic        rs_neg;
  logic        rs_zero;
  logic        rs_eq;
  logic        bit_lo;
  logic        bit_hi;
  npcr_ctl_t   ctl_next;

  assign op      = instruction & MASK_OP;
  assign ri      = instruction & MASK_RI;
  assign rs_neg  = rs_value[63];
  assign rs_zero = (rs_value == 64'sd0);
  assign rs_eq   = (rs_value == rt_value);
  assign bit_lo  = rs_value[{1'b0, instruction[20:16]}];
  assign bit_hi  = rs_value[{1'b1, instruction[20:16]}];

  // First match wins, in the architectural decode order.
  always_comb begin
    ctl_next.sel   = SEL_PLUS4;
    ctl_next.taken = 1'b0;
    if ((instruction & MASK_COP) == PAT_BCZ) begin
      ctl_next.sel = SEL_PLUS8;
    end else if (ri == PAT_BGEZALL || ri == PAT_BGEZL) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = !rs_neg;
    end else if (ri == PAT_BGTZL) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = !rs_neg && !rs_zero;
    end else if (ri == PAT_BLEZL) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = rs_neg || rs_zero;
    end else if (ri == PAT_BLTZALL || ri == PAT_BLTZL) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = rs_neg;
    end else if (op == PAT_BEQL) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = rs_eq;
    end else if (op == PAT_BNEL) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = !rs_eq;
    end else if (op == PAT_J || op == PAT_JAL) begin
      ctl_next.sel = SEL_JUMP;
    end else if ((instruction & MASK_JAL) == PAT_JALR ||
                 (instruction & MASK_JR) == PAT_JR) begin
      ctl_next.sel = SEL_JREG;
    end else if (op == PAT_BEQ) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = rs_eq;
    end else if (ri == PAT_BGEZ || ri == PAT_BGEZAL) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = !rs_neg;
    end else if (ri == PAT_BGTZ) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = !rs_neg && !rs_zero;
    end else if (ri == PAT_BLEZ) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = rs_neg || rs_zero;
    end else if (ri == PAT_BLTZ || ri == PAT_BLTZAL) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = rs_neg;
    end else if (op == PAT_BNE) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = !rs_eq;
    end else if (op == PAT_BBIT0) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = !bit_lo;
    end else if (op == PAT_BBIT032) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = !bit_hi;
    end else if (op == PAT_BBIT1) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = bit_lo;
    end else if (op == PAT_BBIT132) begin
      ctl_next.sel   = SEL_BRANCH;
      ctl_next.taken = bit_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl    <= ctl_next;
      pc_q   <= pc[ADDR_WIDTH-1:0];
      offset <= instruction[15:0];
      index  <= instruction[25:0];
      rs_q   <= rs_value[ADDR_WIDTH-1:0];
    end
  end

endmodule

[rtl/npcr_target.sv]
// Stage 2: computes every candidate address (sequential, branch, jump, register).
// Depends on npcr_pkg.
module npcr_target import npcr_pkg::*; #(
  parameter int ADDR_WIDTH = NPCR_ADDR_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   v_in,
  input  npcr_ctl_t              ctl_in,
  input  logic [ADDR_WIDTH-1:0]  pc_in,
  input  logic [15:0]            offset,
  input  logic [25:0]            index,
  input  logic [ADDR_WIDTH-1:0]  rs_in,
  output logic                   v,
  output npcr_ctl_t              ctl,
  output logic [ADDR_WIDTH-1:0]  seq4,
  output logic [ADDR_WIDTH-1:0]  seq8,
  output logic [ADDR_WIDTH-1:0]  branch,
  output logic [ADDR_WIDTH-1:0]  jump,
  output logic [ADDR_WIDTH-1:0]  jreg
);

  logic [ADDR_WIDTH-1:0] disp;

  // Word offset, sign-extended, plus 4 for the delay slot.
  assign disp = {{(ADDR_WIDTH-18){offset[15]}}, offset, 2'b00} + ADDR_WIDTH'(4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl    <= ctl_in;
      seq4   <= pc_in + ADDR_WIDTH'(4);
      seq8   <= pc_in + ADDR_WIDTH'(8);
      branch <= pc_in + disp;
      jump   <= {pc_in[ADDR_WIDTH-1:28], index, 2'b00};
      jreg   <= rs_in;
    end
  end

endmodule

[rtl/npcr_select.sv]
// Stage 3: picks the final address and holds it in the output register.
// Depends on npcr_pkg.
module npcr_select import npcr_pkg::*; #(
  parameter int ADDR_WIDTH = NPCR_ADDR_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   v_in,
  input  npcr_ctl_t              ctl,
  input  logic [ADDR_WIDTH-1:0]  seq4,
  input  logic [ADDR_WIDTH-1:0]  seq8,
  input  logic [ADDR_WIDTH-1:0]  branch,
  input  logic [ADDR_WIDTH-1:0]  jump,
  input  logic [ADDR_WIDTH-1:0]  jreg,
  output logic                   v,
  output logic [63:0]            next_pc
);

  logic [ADDR_WIDTH-1:0] target;

  always_comb begin
    case (ctl.sel)
      SEL_PLUS4:  target = seq4;
      SEL_PLUS8:  target = seq8;
      SEL_BRANCH: target = ctl.taken ? branch : seq8;
      SEL_JUMP:   target = jump;
      SEL_JREG:   target = jreg;
      default:    target = seq4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      next_pc <= 64'(target);
    end
  end

endmodule
